// File: rtl/core/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg: shared types and constants of the heat stencil step
// Payload structs, pipeline control struct, register indexes and widths.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int MaxCols = 1024;
  localparam int ColW    = $clog2(MaxCols);
  localparam int TempW   = 24;
  localparam int RatioW  = 16;
  localparam int ColsW   = 11;
  localparam int RowsW   = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;
  localparam int LapW    = TempW + 3;
  localparam int ProdW   = LapW + RatioW;
  localparam int SumW    = LapW + 1;
  localparam int RndSh   = 16;

  localparam logic [CfgIdxW-1:0] CfgRatio = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCols  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRows  = 2'd2;

  localparam logic [RatioW-1:0] RatioRst = 16'd10486;
  localparam logic [ColsW-1:0]  ColsRst  = 11'd1000;
  localparam logic [RowsW-1:0]  RowsRst  = 16'd1000;

  typedef logic signed [TempW-1:0] temp_t;
  typedef logic [ColW-1:0]         col_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_in;
    logic                    frame_start;
  } hss_in_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_out;
    logic                    run_last;
    logic                    frame_end;
  } hss_out_t;

  typedef struct packed {
    logic emit;
    logic nz;
    logic last_row;
    logic last_col;
  } hss_ctl_t;

endpackage

// File: rtl/core/hss_line_buf.sv
// ----------------------------------------------------------------------------
// hss_line_buf: two row memories of the heat stencil step
// Newer row read at column and column+1, older row read at column, both
// with registered read data; older-row write forwarded to a same-column read.
// ----------------------------------------------------------------------------
module hss_line_buf (
  input  logic                clk_i,
  input  logic                acc_i,
  input  hss_pkg::col_t       rd_addr_i,
  input  hss_pkg::temp_t      wr_data_i,
  input  logic                old_we_i,
  input  hss_pkg::col_t       old_addr_i,
  output hss_pkg::temp_t      center_o,
  output hss_pkg::temp_t      right_o,
  output hss_pkg::temp_t      up_o
);

  hss_pkg::temp_t newer_mem [hss_pkg::MaxCols];
  hss_pkg::temp_t older_mem [hss_pkg::MaxCols];

  hss_pkg::temp_t center_q;
  hss_pkg::temp_t right_q;
  hss_pkg::temp_t older_rd_q;
  hss_pkg::temp_t byp_val_q;
  logic           byp_q;
  hss_pkg::col_t  rd_next;

  assign rd_next = rd_addr_i + hss_pkg::ColW'(1);

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      center_q            <= newer_mem[rd_addr_i];
      right_q             <= newer_mem[rd_next];
      newer_mem[rd_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      older_rd_q <= older_mem[rd_addr_i];
      byp_q      <= old_we_i && (old_addr_i == rd_addr_i);
      byp_val_q  <= center_q;
    end
    if (old_we_i) begin
      older_mem[old_addr_i] <= center_q;
    end
  end

  assign center_o = center_q;
  assign right_o  = right_q;
  assign up_o     = byp_q ? byp_val_q : older_rd_q;

endmodule

// File: rtl/core/hss_cell.sv
// ----------------------------------------------------------------------------
// hss_cell: one window cell of the heat stencil step
// Loads from the row memory or from its neighbor cell, or clears to zero.
// ----------------------------------------------------------------------------
module hss_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           sel_nbr_i,
  input  logic           clr_i,
  input  hss_pkg::temp_t mem_i,
  input  hss_pkg::temp_t nbr_i,
  output hss_pkg::temp_t q_o
);

  hss_pkg::temp_t val_q;
  hss_pkg::temp_t val_d;

  always_comb begin
    if (clr_i) begin
      val_d = '0;
    end else if (sel_nbr_i) begin
      val_d = nbr_i;
    end else begin
      val_d = mem_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

// File: rtl/core/hss_stencil.sv
// ----------------------------------------------------------------------------
// hss_stencil: arithmetic pipeline of the heat stencil step
// Laplacian stage, ratio product stage, then rounding, add and saturation.
// ----------------------------------------------------------------------------
module hss_stencil (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        in_v_i,
  input  hss_pkg::hss_ctl_t           ctl_i,
  input  hss_pkg::temp_t              up_i,
  input  hss_pkg::temp_t              down_i,
  input  hss_pkg::temp_t              left_i,
  input  hss_pkg::temp_t              center_i,
  input  hss_pkg::temp_t              right_i,
  input  logic [hss_pkg::RatioW-1:0]  ratio_i,
  output logic                        res_v_o,
  output hss_pkg::hss_ctl_t           res_ctl_o,
  output hss_pkg::temp_t              res_o
);

  localparam logic signed [hss_pkg::ProdW-1:0] RndOfs = hss_pkg::ProdW'(1 << (hss_pkg::RndSh - 1));
  localparam logic signed [hss_pkg::SumW-1:0]  TMax   =
    hss_pkg::SumW'((1 << (hss_pkg::TempW - 1)) - 1);
  localparam logic signed [hss_pkg::SumW-1:0]  TMin   =
    -hss_pkg::SumW'(1 << (hss_pkg::TempW - 1));

  logic                               s3_v_q;
  hss_pkg::hss_ctl_t                  s3_ctl_q;
  logic signed [hss_pkg::LapW-1:0]    lap_q;
  logic signed [hss_pkg::LapW-1:0]    lap_d;
  hss_pkg::temp_t                     s3_center_q;

  logic                               s4_v_q;
  hss_pkg::hss_ctl_t                  s4_ctl_q;
  logic signed [hss_pkg::ProdW-1:0]   prod_q;
  logic signed [hss_pkg::ProdW-1:0]   prod_d;
  hss_pkg::temp_t                     s4_center_q;

  logic signed [hss_pkg::ProdW-1:0]   rnd;
  logic signed [hss_pkg::LapW-1:0]    delta;
  logic signed [hss_pkg::SumW-1:0]    sum;

  assign lap_d = hss_pkg::LapW'(up_i) + hss_pkg::LapW'(down_i)
               + hss_pkg::LapW'(left_i) + hss_pkg::LapW'(right_i)
               - (hss_pkg::LapW'(center_i) <<< 2);

  assign prod_d = $signed({1'b0, ratio_i}) * lap_q;

  assign rnd   = prod_q + RndOfs;
  assign delta = rnd[hss_pkg::ProdW-1:hss_pkg::RndSh];
  assign sum   = hss_pkg::SumW'(s4_center_q) + hss_pkg::SumW'(delta);

  always_comb begin
    if (sum > TMax) begin
      res_o = TMax[hss_pkg::TempW-1:0];
    end else if (sum < TMin) begin
      res_o = TMin[hss_pkg::TempW-1:0];
    end else begin
      res_o = sum[hss_pkg::TempW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv_i) begin
      s3_v_q <= in_v_i;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_ctl_q    <= ctl_i;
      lap_q       <= lap_d;
      s3_center_q <= center_i;
      s4_ctl_q    <= s3_ctl_q;
      prod_q      <= prod_d;
      s4_center_q <= s3_center_q;
    end
  end

  assign res_v_o   = s4_v_q;
  assign res_ctl_o = s4_ctl_q;

endmodule

// File: rtl/core/hss_out_reg.sv
// ----------------------------------------------------------------------------
// hss_out_reg: output register of the heat stencil step
// Holds one result and a pending zero border result for last-row requests.
// ----------------------------------------------------------------------------
module hss_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  hss_pkg::hss_ctl_t  ctl_i,
  input  hss_pkg::temp_t     res_i,
  input  logic               stall_i,
  output logic               cap_o,
  output logic               valid_o,
  output hss_pkg::hss_out_t  data_o
);

  logic              out_v_q;
  hss_pkg::hss_out_t out_q;
  logic              pend_q;
  logic              pend_fe_q;
  logic              free;

  assign free  = !out_v_q || !stall_i;
  assign cap_o = free && !pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load_i) begin
      out_v_q <= 1'b1;
      pend_q  <= ctl_i.last_row;
    end else if (pend_q && free) begin
      out_v_q <= 1'b1;
      pend_q  <= 1'b0;
    end else if (free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q.temperature_out <= ctl_i.nz ? res_i : '0;
      out_q.run_last        <= !ctl_i.last_row;
      out_q.frame_end       <= 1'b0;
      pend_fe_q             <= ctl_i.last_col;
    end else if (pend_q && free) begin
      out_q.temperature_out <= '0;
      out_q.run_last        <= 1'b1;
      out_q.frame_end       <= pend_fe_q;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

// File: rtl/core/heat_stencil_step.sv
// ----------------------------------------------------------------------------
// heat_stencil_step: one explicit heat-equation time step, five-point stencil
// Raster stream of Q12.12 cells in, updated cells out one row behind.
// ----------------------------------------------------------------------------
// Takes one cell request per clock unless in_stall_o holds it. A request in
// the last row yields two results (the cell above and its own zero border
// cell) through the single output register, so the register takes no new
// result while a border cell is pending; row-0 requests yield none. Two
// 1024-entry row memories and a three-cell window chain feed a Laplacian
// stage and a 16 x 27 bit product stage; rounding and saturation close the
// pipeline into the output register. The row memories need no clearing.
// ----------------------------------------------------------------------------
module heat_stencil_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  hss_pkg::hss_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output hss_pkg::hss_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [hss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hss_pkg::CfgW-1:0]     cfg_data_i
);

  logic [hss_pkg::RatioW-1:0] ratio_q;
  logic [hss_pkg::ColsW-1:0]  cols_q;
  logic [hss_pkg::RowsW-1:0]  rows_q;

  hss_pkg::col_t              col_q;
  hss_pkg::col_t              col_d;
  logic [hss_pkg::RowsW-1:0]  row_q;
  logic [hss_pkg::RowsW-1:0]  row_d;

  logic                       adv;
  logic                       in_acc;
  hss_pkg::col_t              col;
  logic [hss_pkg::RowsW-1:0]  row;
  logic [hss_pkg::ColsW-1:0]  cols_eff;
  logic [hss_pkg::RowsW-1:0]  rows_eff;
  hss_pkg::hss_ctl_t          ctl;

  logic                       s1_v_q;
  hss_pkg::hss_ctl_t          s1_ctl_q;
  hss_pkg::col_t              s1_col_q;
  hss_pkg::temp_t             s1_t_q;

  logic                       s2_v_q;
  hss_pkg::hss_ctl_t          s2_ctl_q;
  hss_pkg::temp_t             up_q;
  hss_pkg::temp_t             down_q;

  hss_pkg::temp_t             center_rd;
  hss_pkg::temp_t             right_rd;
  hss_pkg::temp_t             up_rd;
  hss_pkg::temp_t             win_left;
  hss_pkg::temp_t             win_center;
  hss_pkg::temp_t             win_right;
  logic                       win_en;

  logic                       res_v;
  hss_pkg::hss_ctl_t          res_ctl;
  hss_pkg::temp_t             res;
  logic                       cap;
  logic                       load;

  assign adv        = !res_v || !res_ctl.emit || cap;
  assign load       = res_v && res_ctl.emit && cap;
  assign in_acc     = in_valid_i && adv;
  assign in_stall_o = !adv;
  assign win_en     = adv && s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= hss_pkg::RatioRst;
      cols_q  <= hss_pkg::ColsRst;
      rows_q  <= hss_pkg::RowsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hss_pkg::CfgRatio: ratio_q <= cfg_data_i[hss_pkg::RatioW-1:0];
        hss_pkg::CfgCols:  cols_q  <= cfg_data_i[hss_pkg::ColsW-1:0];
        hss_pkg::CfgRows:  rows_q  <= cfg_data_i[hss_pkg::RowsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_q < hss_pkg::ColsW'(3)) begin
      cols_eff = hss_pkg::ColsW'(3);
    end else if (32'(cols_q) > hss_pkg::MaxCols) begin
      cols_eff = hss_pkg::ColsW'(hss_pkg::MaxCols);
    end else begin
      cols_eff = cols_q;
    end
    rows_eff = (rows_q < hss_pkg::RowsW'(3)) ? hss_pkg::RowsW'(3) : rows_q;

    col = in_data_i.frame_start ? '0 : col_q;
    row = in_data_i.frame_start ? '0 : row_q;

    ctl.last_col = 32'(col) >= (32'(cols_eff) - 32'd1);
    ctl.last_row = row >= (rows_eff - hss_pkg::RowsW'(1));
    ctl.emit     = row != '0;
    ctl.nz       = (row >= hss_pkg::RowsW'(2)) && (col != '0) && !ctl.last_col;

    if (ctl.last_col) begin
      col_d = '0;
      row_d = ctl.last_row ? '0 : row + hss_pkg::RowsW'(1);
    end else begin
      col_d = col + hss_pkg::ColW'(1);
      row_d = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_acc;
      s2_v_q <= s1_v_q;
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctl_q <= ctl;
      s1_col_q <= col;
      s1_t_q   <= in_data_i.temperature_in;
    end
    if (adv) begin
      s2_ctl_q <= s1_ctl_q;
      up_q     <= up_rd;
      down_q   <= s1_t_q;
    end
  end

  hss_line_buf u_line_buf (
    .clk_i      (clk_i),
    .acc_i      (in_acc),
    .rd_addr_i  (col),
    .wr_data_i  (in_data_i.temperature_in),
    .old_we_i   (win_en),
    .old_addr_i (s1_col_q),
    .center_o   (center_rd),
    .right_o    (right_rd),
    .up_o       (up_rd)
  );

  hss_cell u_cell_right (
    .clk_i     (clk_i),
    .en_i      (win_en),
    .sel_nbr_i (1'b0),
    .clr_i     (s1_ctl_q.last_col),
    .mem_i     (right_rd),
    .nbr_i     ('0),
    .q_o       (win_right)
  );

  hss_cell u_cell_center (
    .clk_i     (clk_i),
    .en_i      (win_en),
    .sel_nbr_i (1'b0),
    .clr_i     (1'b0),
    .mem_i     (center_rd),
    .nbr_i     (win_right),
    .q_o       (win_center)
  );

  hss_cell u_cell_left (
    .clk_i     (clk_i),
    .en_i      (win_en),
    .sel_nbr_i (1'b1),
    .clr_i     (s1_col_q == '0),
    .mem_i     (center_rd),
    .nbr_i     (win_center),
    .q_o       (win_left)
  );

  hss_stencil u_stencil (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_v_i    (s2_v_q),
    .ctl_i     (s2_ctl_q),
    .up_i      (up_q),
    .down_i    (down_q),
    .left_i    (win_left),
    .center_i  (win_center),
    .right_i   (win_right),
    .ratio_i   (ratio_q),
    .res_v_o   (res_v),
    .res_ctl_o (res_ctl),
    .res_o     (res)
  );

  hss_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .ctl_i   (res_ctl),
    .res_i   (res),
    .stall_i (out_stall_i),
    .cap_o   (cap),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule
